// ----- src/sccf_pkg.sv -----
// Shared types and constants for the smartcard character framer.
package sccf_pkg;

	localparam int unsigned DATA_BITS = 8;
	localparam int unsigned ETU_W     = 16;
	localparam int unsigned CNT_W     = ETU_W + 1;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [SLOT_W-1:0] TX_GUARD_END  = 4'd2;
	localparam logic [SLOT_W-1:0] TX_START_SLOT = 4'd2;
	localparam logic [SLOT_W-1:0] TX_DATA_SLOT  = 4'd3;
	localparam logic [SLOT_W-1:0] TX_LAST_DATA  = 4'd10;
	localparam logic [SLOT_W-1:0] TX_PARITY_SLOT = 4'd11;
	localparam logic [SLOT_W-1:0] TX_LAST_SLOT  = 4'd13;
	localparam logic [SLOT_W-1:0] RX_DRIVE_SLOT = 4'd8;
	localparam logic [SLOT_W-1:0] RX_END_SLOT   = 4'd10;
	localparam logic [SLOT_W-1:0] RX_DATA_SLOTS = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_ETU   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE = 2'd1;

	localparam logic [ETU_W-1:0] ETU_RESET   = 16'd8333;
	localparam logic [ETU_W-1:0] PHASE_RESET = 16'd5000;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_TX   = 3'b010,
		MODE_RX   = 3'b100
	} mode_t;

	typedef struct packed {
		logic                 line_in;
		logic                 send_request;
		logic [DATA_BITS-1:0] send_byte;
	} item_t;

	typedef struct packed {
		logic                 line_drive;
		logic                 line_level;
		logic                 rx_valid;
		logic [DATA_BITS-1:0] rx_byte;
		logic                 tx_done;
		logic                 tx_error;
		logic                 busy_res;
	} result_t;

	typedef struct packed {
		logic [ETU_W-1:0] etu_cycles;
		logic [ETU_W-1:0] sample_phase_cycles;
	} cfg_t;

endpackage

// ----- src/smartcard_character_framer.sv -----
// One tick item per cycle while the result side keeps up: an input register feeds
// the framer state logic, whose result goes to an output register. A new item is taken
// every cycle while the result side keeps up; out_stall backs up through one stage.
// Bit timing is counted in items: etu_cycles items per bit, with the first receive
// sample at etu_cycles + sample_phase_cycles items after the falling-edge item.
// Configuration writes are always ready and should be done while the framer is idle.
module smartcard_character_framer import sccf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 line_in,
	input  logic                 send_request,
	input  logic [DATA_BITS-1:0] send_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_drive,
	output logic                 line_level,
	output logic                 rx_valid,
	output logic [DATA_BITS-1:0] rx_byte,
	output logic                 tx_done,
	output logic                 tx_error,
	output logic                 busy_res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ETU_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_comb;
	logic    advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.etu_cycles          <= ETU_RESET;
			cfg_q.sample_phase_cycles <= PHASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ETU:   cfg_q.etu_cycles          <= cfg_data;
				CFG_PHASE: cfg_q.sample_phase_cycles <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.line_in      <= line_in;
			item_s1.send_request <= send_request;
			item_s1.send_byte    <= send_byte;
		end
	end

	sccf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign out_valid  = valid_s2;
	assign line_drive = res_s2.line_drive;
	assign line_level = res_s2.line_level;
	assign rx_valid   = res_s2.rx_valid;
	assign rx_byte    = res_s2.rx_byte;
	assign tx_done    = res_s2.tx_done;
	assign tx_error   = res_s2.tx_error;
	assign busy_res   = res_s2.busy_res;

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed item did not reach the result register");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_done |-> !line_drive && !busy_res)
		else $error("line driven or busy on transmit completion");

	a_rx_tx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rx_valid && tx_done))
		else $error("receive and transmit completion in one item");

	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tx_error || line_level) |-> tx_done || line_drive)
		else $error("error or level flagged without completion or drive");

endmodule

// ----- src/sccf_engine.sv -----
// Framer state and the per-tick transmit/receive sequencing.
module sccf_engine import sccf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t                mode_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DATA_BITS-1:0] shift_q;
	logic                 par_q;
	logic                 prev_line_q;

	mode_t                mode_n;
	logic [SLOT_W-1:0]    slot_n;
	logic [CNT_W-1:0]     cnt_n;
	logic [DATA_BITS-1:0] shift_n;
	logic                 par_n;

	always_comb begin
		logic              started;
		logic [CNT_W:0]    tx_next;
		logic [CNT_W-1:0]  rx_next;
		logic [CNT_W-1:0]  limit;
		logic [SLOT_W-1:0] slot_inc;
		logic [SLOT_W-1:0] bit_sel;
		mode_n   = mode_q;
		slot_n   = slot_q;
		cnt_n    = cnt_q;
		shift_n  = shift_q;
		par_n    = par_q;
		started  = 1'b0;
		res      = '0;
		tx_next  = '0;
		rx_next  = '0;
		limit    = '0;
		slot_inc = '0;
		bit_sel  = '0;

		if (mode_q == MODE_IDLE) begin
			if (item.send_request) begin
				mode_n  = MODE_TX;
				slot_n  = '0;
				cnt_n   = '0;
				shift_n = item.send_byte;
				par_n   = ^item.send_byte;
			end else if (prev_line_q && !item.line_in) begin
				mode_n  = MODE_RX;
				slot_n  = '0;
				cnt_n   = '0;
				shift_n = '0;
				started = 1'b1;
			end
		end

		unique case (mode_n)
			MODE_TX: begin
				if (slot_n >= TX_LAST_SLOT) begin
					// released tick: a low line is the receiver's error signal
					res.tx_done  = 1'b1;
					res.tx_error = !item.line_in;
					mode_n       = MODE_IDLE;
					slot_n       = '0;
					cnt_n        = '0;
				end else begin
					res.line_drive = 1'b1;
					bit_sel        = slot_n - TX_DATA_SLOT;
					if (slot_n < TX_GUARD_END)
						res.line_level = 1'b1;
					else if (slot_n == TX_START_SLOT)
						res.line_level = 1'b0;
					else if (slot_n <= TX_LAST_DATA)
						res.line_level = shift_n[bit_sel[2:0]];
					else if (slot_n == TX_PARITY_SLOT)
						res.line_level = par_n;
					else
						res.line_level = 1'b1;
					tx_next = {1'b0, cnt_n} + 1'b1;
					if (tx_next >= {2'b00, cfg.etu_cycles}) begin
						cnt_n  = '0;
						slot_n = slot_n + 1'b1;
					end else begin
						cnt_n = tx_next[CNT_W-1:0];
					end
				end
			end
			MODE_RX: begin
				if (!started) begin
					limit = (slot_n == '0)
						? ({1'b0, cfg.etu_cycles} + {1'b0, cfg.sample_phase_cycles})
						: {1'b0, cfg.etu_cycles};
					if (slot_n == RX_DRIVE_SLOT) begin
						res.line_drive = 1'b1;
						res.line_level = 1'b1;
					end
					rx_next = cnt_n + 1'b1;
					if (rx_next >= limit) begin
						cnt_n = '0;
						if (slot_n < RX_DATA_SLOTS)
							shift_n = {item.line_in, shift_n[DATA_BITS-1:1]};
						slot_inc = slot_n + 1'b1;
						if (slot_inc >= RX_END_SLOT) begin
							res.rx_valid = 1'b1;
							res.rx_byte  = shift_n;
							mode_n       = MODE_IDLE;
							slot_n       = '0;
						end else begin
							slot_n = slot_inc;
						end
					end else begin
						cnt_n = rx_next;
					end
				end
			end
			default: ;
		endcase

		res.busy_res = (mode_n != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			slot_q      <= '0;
			cnt_q       <= '0;
			shift_q     <= '0;
			par_q       <= 1'b0;
			prev_line_q <= 1'b1;
		end else if (step) begin
			mode_q      <= mode_n;
			slot_q      <= slot_n;
			cnt_q       <= cnt_n;
			shift_q     <= shift_n;
			par_q       <= par_n;
			prev_line_q <= item.line_in;
		end
	end

endmodule

// ----- verif/sccf_tick_checker.sv -----
// Tick checker for the smartcard character framer: predicts each tick and compares results.
module sccf_tick_checker import sccf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 line_in,
	input  logic                 send_request,
	input  logic [DATA_BITS-1:0] send_byte,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 line_drive,
	input  logic                 line_level,
	input  logic                 rx_valid,
	input  logic [DATA_BITS-1:0] rx_byte,
	input  logic                 tx_done,
	input  logic                 tx_error,
	input  logic                 busy_res,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ETU_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [ETU_W-1:0]     etu;
	logic [ETU_W-1:0]     phase;
	mode_t                md;
	logic [SLOT_W-1:0]    slot;
	logic [CNT_W-1:0]     cnt;
	logic [DATA_BITS-1:0] shreg;
	logic                 par;
	logic                 prev_line;
	int                   errs;
	result_t              expected_ticks[$];

	function automatic result_t framer_tick(item_t it);
		result_t          r;
		logic             started;
		logic [CNT_W-1:0] lim;
		r = '0;
		started = 1'b0;
		if (md != MODE_TX && md != MODE_RX) begin
			md = MODE_IDLE;
			// a request beats a simultaneous falling edge
			if (it.send_request) begin
				md = MODE_TX;
				slot = '0;
				cnt = '0;
				shreg = it.send_byte;
				par = ^it.send_byte;
			end else if (prev_line && !it.line_in) begin
				md = MODE_RX;
				slot = '0;
				cnt = '0;
				shreg = '0;
				started = 1'b1;
			end
		end
		if (md == MODE_TX) begin
			if (slot >= TX_LAST_SLOT) begin
				// released tick: a low line is the card's error signal
				r.tx_done = 1'b1;
				r.tx_error = !it.line_in;
				md = MODE_IDLE;
				slot = '0;
				cnt = '0;
			end else begin
				r.line_drive = 1'b1;
				if (slot < TX_GUARD_END)
					r.line_level = 1'b1;
				else if (slot == TX_START_SLOT)
					r.line_level = 1'b0;
				else if (slot <= TX_LAST_DATA)
					r.line_level = shreg[3'(slot - TX_DATA_SLOT)];
				else if (slot == TX_PARITY_SLOT)
					r.line_level = par;
				else
					r.line_level = 1'b1;
				if (int'(cnt) + 1 >= int'(etu)) begin
					cnt = '0;
					slot++;
				end else begin
					cnt++;
				end
			end
		end else if (md == MODE_RX && !started) begin
			lim = (slot == '0) ? CNT_W'(etu) + CNT_W'(phase) : CNT_W'(etu);
			if (slot == RX_DRIVE_SLOT) begin
				r.line_drive = 1'b1;
				r.line_level = 1'b1;
			end
			cnt++;
			if (cnt >= lim) begin
				cnt = '0;
				if (slot < RX_DATA_SLOTS)
					shreg = {it.line_in, shreg[DATA_BITS-1:1]};
				slot++;
				if (slot >= RX_END_SLOT) begin
					r.rx_valid = 1'b1;
					r.rx_byte = shreg;
					md = MODE_IDLE;
					slot = '0;
				end
			end
		end
		prev_line = it.line_in;
		r.busy_res = (md == MODE_TX || md == MODE_RX);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			etu = ETU_RESET;
			phase = PHASE_RESET;
			md = MODE_IDLE;
			slot = '0;
			cnt = '0;
			shreg = '0;
			par = 1'b0;
			prev_line = 1'b1;
			expected_ticks.delete();
			errs = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {line_drive, line_level, rx_valid, rx_byte, tx_done, tx_error, busy_res};
				if (expected_ticks.size() == 0) begin
					$display("%0t: result with no item outstanding, expected none got %0h",
						$realtime, got);
					errs++;
				end else begin
					want = expected_ticks.pop_front();
					check_field("line_drive", want.line_drive, got.line_drive);
					check_field("line_level", want.line_level, got.line_level);
					check_field("rx_valid", want.rx_valid, got.rx_valid);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("tx_done", want.tx_done, got.tx_done);
					check_field("tx_error", want.tx_error, got.tx_error);
					check_field("busy_res", want.busy_res, got.busy_res);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ETU:   etu = cfg_data;
					CFG_PHASE: phase = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_ticks.push_back(framer_tick({line_in, send_request, send_byte}));
		end
		mismatches <= errs;
		pending <= expected_ticks.size();
	end

endmodule

// ----- verif/smartcard_character_framer_tb.sv -----
// Testbench top for the smartcard character framer: tick stimulus, back-pressure and verdict.
module smartcard_character_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sccf_pkg::*;

	localparam int PHASE_TICKS    = 330;
	localparam int FINAL_TICKS    = 100;
	localparam int TOTAL_TICKS    = 1900;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 line_in = 1'b1;
	logic                 send_request = 1'b0;
	logic [DATA_BITS-1:0] send_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 line_drive;
	logic                 line_level;
	logic                 rx_valid;
	logic [DATA_BITS-1:0] rx_byte;
	logic                 tx_done;
	logic                 tx_error;
	logic                 busy_res;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ETU;
	logic [ETU_W-1:0]     cfg_data = '0;

	int mismatches;
	int pending;
	int snd_pct = 0;
	int rcv_pct = 0;
	int ticks_sent = 0;
	int chars_sent = 0;
	int chars_received = 0;
	int noise_bursts = 0;
	int settings_used = 0;
	int cur_etu = ETU_RESET;
	int cur_phase = PHASE_RESET;
	int stuck_cycles = 0;

	smartcard_character_framer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_in      (line_in),
		.send_request (send_request),
		.send_byte    (send_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_drive   (line_drive),
		.line_level   (line_level),
		.rx_valid     (rx_valid),
		.rx_byte      (rx_byte),
		.tx_done      (tx_done),
		.tx_error     (tx_error),
		.busy_res     (busy_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	sccf_tick_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_in      (line_in),
		.send_request (send_request),
		.send_byte    (send_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_drive   (line_drive),
		.line_level   (line_level),
		.rx_valid     (rx_valid),
		.rx_byte      (rx_byte),
		.tx_done      (tx_done),
		.tx_error     (tx_error),
		.busy_res     (busy_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < rcv_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no handshake for %0d cycles", $realtime, stuck_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	function automatic int at_least_one(input int v);
		return (v < 1) ? 1 : v;
	endfunction

	// one tick item; the idle profile follows overall progress
	task automatic drive_tick(input logic l, input logic r, input logic [7:0] b);
		if (ticks_sent < TOTAL_TICKS / 3) begin
			snd_pct = 14;
			rcv_pct = 74;
		end else if (ticks_sent < 2 * TOTAL_TICKS / 3) begin
			snd_pct = 74;
			rcv_pct = 14;
		end else begin
			snd_pct = 0;
			rcv_pct = 0;
		end
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		line_in <= l;
		send_request <= r;
		send_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
	endtask

	// drains the pipeline, then writes both timing registers
	task automatic apply_setting(input int etu, input int phase);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ETU;
		cfg_data <= ETU_W'(etu);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= CFG_PHASE;
		cfg_data <= ETU_W'(phase);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_etu = etu;
		cur_phase = phase;
		settings_used++;
	endtask

	// framer must be idle; the tick after the request window ends on the released slot
	task automatic send_char(input logic [7:0] b, input logic err, input logic on_edge);
		int span;
		int t;
		span = 13 * at_least_one(cur_etu);
		drive_tick(!on_edge, 1'b1, b);
		for (t = 1; t < span; t++)
			drive_tick(($urandom_range(9) == 0) ? 1'($urandom_range(1)) : 1'b1,
				(t == 1) || ($urandom_range(15) == 0), 8'($urandom_range(255)));
		drive_tick(!err, 1'b0, 8'($urandom_range(255)));
		drive_tick(1'b1, 1'b0, 8'($urandom_range(255)));
		chars_sent++;
	endtask

	// start bit, data LSB first, even parity, then idle high until delivery
	task automatic receive_char(input logic [7:0] b, input logic noisy);
		int   e;
		int   stop;
		int   t;
		int   k;
		logic l;
		e = at_least_one(cur_etu);
		stop = at_least_one(cur_etu + cur_phase) + 9 * e;
		drive_tick(1'b1, 1'b0, 8'($urandom_range(255)));
		for (t = 0; t <= stop; t++) begin
			k = t / e - 1;
			if (k < 0)
				l = 1'b0;
			else if (k < 8)
				l = b[k];
			else if (k == 8)
				l = ^b;
			else
				l = 1'b1;
			if (noisy && t > 0 && $urandom_range(3) == 0)
				l = 1'($urandom_range(1));
			drive_tick(l, (t > 0) && ($urandom_range(19) == 0), 8'($urandom_range(255)));
		end
		chars_received++;
	endtask

	// random line activity, then long enough high for any started character to finish
	task automatic line_noise;
		int   n;
		int   t;
		int   settle;
		logic l;
		n = $urandom_range(60, 20);
		l = 1'b1;
		for (t = 0; t < n; t++) begin
			if ($urandom_range(3) == 0)
				l = ~l;
			drive_tick(l, $urandom_range(19) == 0, 8'($urandom_range(255)));
		end
		settle = at_least_one(cur_etu + cur_phase) + 9 * at_least_one(cur_etu);
		if (settle < 13 * at_least_one(cur_etu))
			settle = 13 * at_least_one(cur_etu);
		for (t = 0; t < settle + 2; t++)
			drive_tick(1'b1, 1'b0, 8'($urandom_range(255)));
		noise_bursts++;
	endtask

	task automatic random_phase(input int etu, input int phase, input int n);
		int start;
		int sel;
		int gap;
		apply_setting(etu, phase);
		start = ticks_sent;
		while (ticks_sent - start < n) begin
			sel = $urandom_range(99);
			if (sel < 40)
				send_char(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(9) == 0);
			else if (sel < 80)
				receive_char(8'($urandom_range(255)), $urandom_range(4) == 0);
			else
				line_noise();
			for (gap = $urandom_range(6); gap > 0; gap--)
				drive_tick(1'b1, 1'b0, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int etu_pick;
		int t;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero timing: every slot is one tick, first sample right after the edge
		apply_setting(0, 0);
		drive_tick(1'b1, 1'b0, 8'h00);
		send_char(8'hFF, 1'b1, 1'b1);
		receive_char(8'h80, 1'b0);

		random_phase(16, 1, PHASE_TICKS);
		random_phase(16, 8, PHASE_TICKS);
		random_phase(18, 30, PHASE_TICKS);
		etu_pick = $urandom_range(24, 16);
		random_phase(etu_pick, $urandom_range(etu_pick - 1, 1), PHASE_TICKS);

		// widest timing: a character starts but cannot complete within the run
		apply_setting(65535, 65535);
		drive_tick(1'b1, 1'b0, 8'($urandom_range(255)));
		drive_tick(1'b0, 1'b0, 8'($urandom_range(255)));
		for (t = 0; t < FINAL_TICKS; t++)
			drive_tick(1'($urandom_range(1)), $urandom_range(7) == 0, 8'($urandom_range(255)));

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d tick items over %0d timing settings, from zero ETU to the widest",
			ticks_sent, settings_used);
		$display("run: %0d characters sent, %0d received, %0d noise bursts",
			chars_sent, chars_received, noise_bursts);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sccf_pkg.sv
src/sccf_engine.sv
src/smartcard_character_framer.sv
verif/sccf_tick_checker.sv
verif/smartcard_character_framer_tb.sv
